### src/ctsc_pkg.sv
// ctsc_pkg: shared types and constants for the tab/space converter.
// Used by ctsc_div and c_aware_tab_space_converter_unit; no dependencies.
package ctsc_pkg;

  // Character codes the lexer and the column logic look at
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_NL     = 8'd10;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_DQUOTE = 8'd34;
  localparam logic [7:0] CH_SQUOTE = 8'd39;
  localparam logic [7:0] CH_STAR   = 8'd42;
  localparam logic [7:0] CH_SLASH  = 8'd47;
  localparam logic [7:0] CH_BSLASH = 8'd92;

  // Register indexes (byte address / 4)
  localparam int unsigned REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_TAB_SIZE     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SPACE_TO_TAB = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_COMMENTS_TOO = 2'd2;

  typedef enum logic [4:0] {
    LEX_CODE      = 5'b00001,
    LEX_CHAR      = 5'b00010,
    LEX_STR       = 5'b00100,
    LEX_LINE_CMT  = 5'b01000,
    LEX_BLOCK_CMT = 5'b10000
  } lex_mode_t;

  typedef struct packed {
    lex_mode_t mode;
    logic      esc;
  } lex_t;

  // Divider request / status
  typedef struct packed {
    logic       start;
    logic [7:0] divisor;
  } ctsc_div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ctsc_div_sts_t;

endpackage

### src/c_aware_tab_space_converter_unit.sv
// c_aware_tab_space_converter_unit: top level of the C-aware tab/space converter.
// Depends on ctsc_pkg and ctsc_div.
//
// Usage:
//  - Input channel (in_valid/in_stall, in_byte, end_of_text): one text byte per
//    word. end_of_text closes the final line and returns the lexer and column
//    state to reset; in_byte is ignored on that word.
//  - Output channel (out_valid/out_stall): exactly one result word per input
//    word: tab_count tabs, then space_count spaces, then out_byte if byte_valid.
//  - APB port: tab_size at 0x0, space_to_tab at 0x4, comments_too at 0x8.
//    Write only while the block is idle.
//  - Divider use: a plain byte goes from accept through S_EVAL and S_FINISH to the
//    result register without the divider. A tab in code runs the divider once
//    (CW = column width, 12 by default). A text byte in space_to_tab mode after a
//    gap of two or more columns runs it twice. The shared divider yields one
//    quotient bit per cycle.
//  - in_stall is high from accept until the result is loaded into the output
//    register, so no new word is taken while one is in work; the next word can
//    be taken while that result still waits.
//  - If the receiver stalls, the finished result waits in the sequencer until
//    the output register is free; nothing is dropped.
//  - Reset (rst, synchronous) clears the lexer, columns and handshakes and
//    loads tab_size 8, space_to_tab 0, comments_too 0.
module c_aware_tab_space_converter_unit import ctsc_pkg::*; #(
  parameter int unsigned MAX_COLUMN = 4095
) (
  input  logic        clk,
  input  logic        rst,
  // APB config
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input words
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        end_of_text,
  // result words
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] tab_count,
  output logic [11:0] space_count,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        column_overflow
);

  localparam int unsigned CW = $clog2(MAX_COLUMN + 1);       // column width
  localparam int unsigned SW = ((CW > 8) ? CW : 8) + 1;       // column sum width
  localparam logic [CW-1:0] MAX_COL = CW'(MAX_COLUMN);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EVAL   = 5'b00010,
    S_DIV_A  = 5'b00100,
    S_DIV_B  = 5'b01000,
    S_FINISH = 5'b10000
  } seq_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [7:0] tab_size;
  logic       space_to_tab;
  logic       comments_too;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tab_size     <= 8'd8;
      space_to_tab <= 1'b0;
      comments_too <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_TAB_SIZE:     tab_size     <= pwdata[7:0];
        REG_SPACE_TO_TAB: space_to_tab <= pwdata[0];
        REG_COMMENTS_TOO: comments_too <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_TAB_SIZE:     prdata = {24'd0, tab_size};
      REG_SPACE_TO_TAB: prdata = {31'd0, space_to_tab};
      REG_COMMENTS_TOO: prdata = {31'd0, comments_too};
      default:          prdata = 32'd0;
    endcase
  end

  // tab_size 0 behaves as 1
  logic [7:0] ts;
  assign ts = (tab_size == 8'd0) ? 8'd1 : tab_size;

  // ---------------------------------------------------------------------------
  // Line state
  // ---------------------------------------------------------------------------
  seq_t            seq, seq_next;
  lex_mode_t       lex_mode, lex_mode_next;
  logic            escape_pair_seen, escape_pair_seen_next;
  logic [7:0]      previous_byte, previous_byte_next;
  logic [CW-1:0]   emitted_column, emitted_column_next;
  logic [CW-1:0]   pending_column, pending_column_next;
  logic            line_has_text, line_has_text_next;
  logic [1:0]      blank_line_run, blank_line_run_next;

  // accepted word
  logic [7:0]      item_byte;
  logic            item_eot;

  // first division result (dividend: pending for a tab, emitted for a gap)
  logic [CW-1:0]   qa;
  logic [7:0]      ra;

  ctsc_div_req_t   div_req;
  ctsc_div_sts_t   div_sts;
  logic [CW-1:0]   div_dividend;
  logic [CW-1:0]   div_q;
  logic [7:0]      div_r;

  ctsc_div #(.DW(CW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .req       (div_req),
    .dividend  (div_dividend),
    .sts       (div_sts),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // ---------------------------------------------------------------------------
  // Word classification (state is stable until S_FINISH)
  // ---------------------------------------------------------------------------
  logic in_code, is_space, is_tab, is_text, gap, stt_go;

  assign in_code  = (lex_mode == LEX_CODE);
  assign is_space = !item_eot && in_code && (item_byte == CH_SPACE);
  assign is_tab   = !item_eot && in_code && (item_byte == CH_TAB);
  assign is_text  = !item_eot && !is_space && !is_tab && (item_byte != CH_NL);
  assign gap      = (pending_column > emitted_column);
  // a one-column gap is always a space
  assign stt_go   = is_text && space_to_tab && gap &&
                    ((SW'(emitted_column) + SW'(1)) != SW'(pending_column));

  logic in_acc, out_acc, out_free;
  assign in_stall = (seq != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign out_free = !out_valid || !out_stall;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    seq_next         = seq;
    div_req.start    = 1'b0;
    div_req.divisor  = ts;
    div_dividend     = pending_column;
    case (seq)
      S_IDLE: begin
        if (in_acc) seq_next = S_EVAL;
      end
      S_EVAL: begin
        if (is_tab) begin
          div_req.start = 1'b1;
          seq_next      = S_DIV_A;
        end else if (stt_go) begin
          div_req.start = 1'b1;
          div_dividend  = emitted_column;
          seq_next      = S_DIV_A;
        end else begin
          seq_next = S_FINISH;
        end
      end
      S_DIV_A: begin
        if (div_sts.done) begin
          if (stt_go) begin
            div_req.start = 1'b1;
            seq_next      = S_DIV_B;
          end else begin
            seq_next = S_FINISH;
          end
        end
      end
      S_DIV_B: begin
        if (div_sts.done) seq_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) seq_next = S_IDLE;
      end
      default: seq_next = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Lexer step: quotes, comments, backslash pairs
  // ---------------------------------------------------------------------------
  function automatic lex_t lex_step(input logic [7:0] c, input logic [7:0] last_in,
                                    input lex_mode_t m, input logic esc_in,
                                    input logic cmt_too);
    lex_t       r;
    logic [7:0] last;
    r.mode = m;
    r.esc  = esc_in;
    last   = last_in;
    if (m != LEX_CODE) begin
      if (esc_in) begin
        last  = 8'd0;
        r.esc = 1'b0;
      end else if (c == CH_BSLASH && last_in == CH_BSLASH &&
                   (m == LEX_CHAR || m == LEX_STR)) begin
        r.esc = 1'b1;
      end
      if (m == LEX_CHAR && c == CH_SQUOTE && last != CH_BSLASH)
        r.mode = LEX_CODE;
      else if (m == LEX_STR && c == CH_DQUOTE && last != CH_BSLASH)
        r.mode = LEX_CODE;
      else if (m == LEX_LINE_CMT && c == CH_NL)
        r.mode = LEX_CODE;
      else if (m == LEX_BLOCK_CMT && c == CH_SLASH && last == CH_STAR)
        r.mode = LEX_CODE;
      if (r.mode == LEX_CODE) r.esc = 1'b0;
    end else begin
      if (c == CH_SQUOTE)
        r.mode = LEX_CHAR;
      else if (c == CH_DQUOTE)
        r.mode = LEX_STR;
      else if (!cmt_too && c == CH_SLASH && last_in == CH_SLASH)
        r.mode = LEX_LINE_CMT;
      else if (!cmt_too && c == CH_STAR && last_in == CH_SLASH)
        r.mode = LEX_BLOCK_CMT;
    end
    return r;
  endfunction

  function automatic logic [11:0] cnt_clamp(input logic [CW-1:0] v);
    logic [11:0] r;
    if (32'(v) > 32'd4095) r = 12'd4095;
    else                   r = 12'(v);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result and next line state, evaluated in S_FINISH
  // ---------------------------------------------------------------------------
  logic [CW-1:0] tabs_w, spaces_w;
  logic [SW-1:0] col_sum;
  logic [CW-1:0] col_new;
  logic          col_ov;
  logic [7:0]    res_byte;
  logic          res_valid;
  lex_t          lex_res;
  logic [1:0]    blank_inc;

  always_comb begin
    lex_mode_next         = lex_mode;
    escape_pair_seen_next = escape_pair_seen;
    previous_byte_next    = previous_byte;
    emitted_column_next   = emitted_column;
    pending_column_next   = pending_column;
    line_has_text_next    = line_has_text;
    blank_line_run_next   = blank_line_run;
    tabs_w    = '0;
    spaces_w  = '0;
    res_byte  = 8'd0;
    res_valid = 1'b0;
    lex_res   = lex_step(item_byte, previous_byte, lex_mode, escape_pair_seen, comments_too);
    blank_inc = (!line_has_text && blank_line_run != 2'd3) ? blank_line_run + 2'd1
                                                            : blank_line_run;

    // column sum for space, tab and text words
    if (is_space)
      col_sum = SW'(pending_column) + SW'(1);
    else if (is_tab)
      col_sum = SW'(pending_column) - SW'(ra) + SW'(ts);  // next tab stop
    else
      col_sum = SW'(pending_column) + SW'(1);
    col_ov  = (col_sum > SW'(MAX_COLUMN));
    col_new = col_ov ? MAX_COL : col_sum[CW-1:0];

    if (item_eot) begin
      col_ov = 1'b0;
      if (line_has_text || (pending_column != '0 && blank_line_run == 2'd1)) begin
        res_byte  = CH_NL;
        res_valid = 1'b1;
      end
      lex_mode_next         = LEX_CODE;
      escape_pair_seen_next = 1'b0;
      previous_byte_next    = 8'd0;
      emitted_column_next   = '0;
      pending_column_next   = '0;
      line_has_text_next    = 1'b0;
      blank_line_run_next   = 2'd0;
    end else begin
      previous_byte_next = item_byte;
      if (is_space || is_tab) begin
        pending_column_next = col_new;
      end else if (is_text) begin
        if (stt_go) begin
          // qa: emitted/ts, div_q: pending/ts
          if (qa == div_q) begin
            spaces_w = pending_column - emitted_column;
          end else begin
            tabs_w   = div_q - qa;
            spaces_w = CW'(div_r);
          end
        end else if (gap) begin
          spaces_w = pending_column - emitted_column;
        end
        res_byte              = item_byte;
        res_valid             = 1'b1;
        blank_line_run_next   = 2'd0;
        line_has_text_next    = 1'b1;
        emitted_column_next   = col_new;
        pending_column_next   = col_new;
        lex_mode_next         = lex_res.mode;
        escape_pair_seen_next = lex_res.esc;
      end else begin
        // newline: trailing whitespace dropped, blank runs collapse
        col_ov              = 1'b0;
        blank_line_run_next = blank_inc;
        if (line_has_text || blank_inc == 2'd1) begin
          res_byte  = CH_NL;
          res_valid = 1'b1;
        end
        emitted_column_next   = '0;
        pending_column_next   = '0;
        line_has_text_next    = 1'b0;
        lex_mode_next         = lex_res.mode;
        escape_pair_seen_next = lex_res.esc;
      end
    end
  end

  logic commit;
  assign commit = (seq == S_FINISH) && out_free;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      seq              <= S_IDLE;
      lex_mode         <= LEX_CODE;
      escape_pair_seen <= 1'b0;
      previous_byte    <= 8'd0;
      emitted_column   <= '0;
      pending_column   <= '0;
      line_has_text    <= 1'b0;
      blank_line_run   <= 2'd0;
      out_valid        <= 1'b0;
    end else begin
      seq <= seq_next;
      if (commit) begin
        lex_mode         <= lex_mode_next;
        escape_pair_seen <= escape_pair_seen_next;
        previous_byte    <= previous_byte_next;
        emitted_column   <= emitted_column_next;
        pending_column   <= pending_column_next;
        line_has_text    <= line_has_text_next;
        blank_line_run   <= blank_line_run_next;
        out_valid        <= 1'b1;
      end else if (out_acc) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_byte <= in_byte;
      item_eot  <= end_of_text;
    end
    if (seq == S_DIV_A && div_sts.done) begin
      qa <= div_q;
      ra <= div_r;
    end
    if (commit) begin
      tab_count       <= cnt_clamp(tabs_w);
      space_count     <= cnt_clamp(spaces_w);
      out_byte        <= res_byte;
      byte_valid      <= res_valid;
      column_overflow <= col_ov;
    end
  end

`ifndef SYNTHESIS
  // a word is never taken while the divider is still working
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_acc |-> !div_sts.busy)
    else $error("input word accepted while divider busy");

  // the divider is never restarted mid-operation
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_sts.busy)
    else $error("divider restarted while busy");

  // done only follows a busy cycle
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    div_sts.done |-> $past(div_sts.busy))
    else $error("divider done without a preceding busy cycle");

  // a result without a byte carries no whitespace
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> tab_count == 12'd0 && space_count == 12'd0)
    else $error("whitespace counts on a result with no byte");
`endif

endmodule

### src/ctsc_div.sv
// ctsc_div: restoring divider, one quotient bit per cycle, 8-bit divisor.
// Depends on ctsc_pkg (request/status structs).
module ctsc_div import ctsc_pkg::*; #(
  parameter int unsigned DW = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  ctsc_div_req_t      req,
  input  logic [DW-1:0]      dividend,
  output ctsc_div_sts_t      sts,
  output logic [DW-1:0]      quotient,
  output logic [7:0]         remainder
);

  localparam int unsigned CNT_W = $clog2(DW + 1);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [DW-1:0]    dq;     // dividend shifts out, quotient shifts in
  logic [7:0]       rem;
  logic [7:0]       dvsr;
  logic [8:0]       trial;
  logic [8:0]       diff;
  logic             fits;

  assign trial = {rem, dq[DW-1]};
  assign diff  = trial - {1'b0, dvsr};
  assign fits  = (trial >= {1'b0, dvsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      // done pulses for one cycle after the last quotient bit
      done <= busy && !req.start && (cnt == CNT_W'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DW);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dq   <= dividend;
      rem  <= 8'd0;
      dvsr <= req.divisor;
    end else if (busy) begin
      dq  <= {dq[DW-2:0], fits};
      rem <= fits ? diff[7:0] : trial[7:0];
    end
  end

  assign sts.busy  = busy;
  assign sts.done  = done;
  assign quotient  = dq;
  assign remainder = rem;

endmodule
